// ----- rtl/core/osm_pkg.sv -----
// Shared types and constants for the order-statistic multiset.
package osm_pkg;

  localparam int KEY_BITS   = 12;
  localparam int COUNT_BITS = 16;
  localparam int POS_BITS   = 16;
  localparam int REQ_BITS   = 3;
  localparam int STAT_BITS  = 2;
  localparam int NODE_BITS  = KEY_BITS + 1;
  localparam int RANK_BITS  = COUNT_BITS + 1;
  localparam int CMP_BITS   = (COUNT_BITS > POS_BITS) ? COUNT_BITS : POS_BITS;

  localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;
  localparam logic [NODE_BITS-1:0]  ROOT      = NODE_BITS'(1);
  localparam logic [NODE_BITS-1:0]  ROOT_LEFT = NODE_BITS'(2);

  localparam logic [REQ_BITS-1:0] REQ_INSERT = 3'd0;
  localparam logic [REQ_BITS-1:0] REQ_REMOVE = 3'd1;
  localparam logic [REQ_BITS-1:0] REQ_RANK   = 3'd2;
  localparam logic [REQ_BITS-1:0] REQ_KTH    = 3'd3;
  localparam logic [REQ_BITS-1:0] REQ_PRED   = 3'd4;
  localparam logic [REQ_BITS-1:0] REQ_SUCC   = 3'd5;

  localparam logic [STAT_BITS-1:0] ST_OK     = 2'd0;
  localparam logic [STAT_BITS-1:0] ST_ABSENT = 2'd1;
  localparam logic [STAT_BITS-1:0] ST_FULL   = 2'd2;

  typedef struct packed {
    logic [REQ_BITS-1:0]        req_type;
    logic signed [KEY_BITS-1:0] key;
    logic [POS_BITS-1:0]        position;
  } osm_in_t;

  typedef struct packed {
    logic signed [KEY_BITS-1:0] found_key;
    logic [RANK_BITS-1:0]       key_rank;
    logic [STAT_BITS-1:0]       status;
  } osm_out_t;

endpackage

// ----- rtl/core/order_statistic_multiset.sv -----
// Order-statistic multiset of signed keys held as a counting segment tree in one RAM.
//
// The block stores a multiset of signed keys and serves insert, remove, rank, k-th
// smallest, predecessor and successor requests, one item at a time, one result per
// item. All work goes through a single tree RAM with one write and one registered
// read port, walked one tree level per cycle by a small sequencer. Insert and
// remove walk from the leaf up to the root, rank sums counts up the leaf path,
// k-th smallest descends from the root, and predecessor or successor first sum
// counts up the leaf path and then descend from the root. After reset the block
// clears all 2^(KEY_BITS+1) tree nodes, one per cycle, and accepts no item until
// that pass ends. A finished result sits in the output register while the next
// item is already accepted.
module order_statistic_multiset (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  osm_pkg::osm_in_t in_data,
  output logic             out_valid,
  input  logic             out_ready,
  output osm_pkg::osm_out_t out_data
);

  import osm_pkg::*;

  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_UPD   = 3'd2;
  localparam logic [2:0] S_CB    = 3'd3;
  localparam logic [2:0] S_CBT   = 3'd4;
  localparam logic [2:0] S_KTH   = 3'd5;
  localparam logic [2:0] S_DONE  = 3'd6;

  logic [2:0]            state_r, state_nxt;
  logic [NODE_BITS-1:0]  clr_r, clr_nxt;
  logic [NODE_BITS-1:0]  nd_r, nd_nxt;
  logic                  first_r, first_nxt;
  logic [REQ_BITS-1:0]   req_r, req_nxt;
  logic [COUNT_BITS-1:0] k_r, k_nxt;
  logic [COUNT_BITS-1:0] acc_r, acc_nxt;
  logic                  pend_vld_r, pend_vld_nxt;
  logic                  pend_add_r, pend_add_nxt;
  logic [COUNT_BITS-1:0] total_r, total_nxt;
  osm_out_t              res_r, res_nxt;
  logic                  out_valid_r, out_valid_nxt;
  osm_out_t              out_data_r, out_data_nxt;

  logic                  wr_en;
  logic [NODE_BITS-1:0]  wr_addr;
  logic [COUNT_BITS-1:0] wr_data;
  logic [NODE_BITS-1:0]  rd_addr;
  logic [COUNT_BITS-1:0] rdata;

  logic [NODE_BITS-1:0]  leaf;
  logic [COUNT_BITS-1:0] cb_sum;
  logic                  go_right;

  osm_ram #(
    .ADDR_BITS(NODE_BITS),
    .DATA_BITS(COUNT_BITS)
  ) u_tree (
    .clk    (clk),
    .wr_en  (wr_en),
    .wr_addr(wr_addr),
    .wr_data(wr_data),
    .rd_addr(rd_addr),
    .rd_data(rdata)
  );

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  assign leaf   = {1'b1, ~in_data.key[KEY_BITS-1], in_data.key[KEY_BITS-2:0]};
  assign cb_sum = acc_r + ((pend_vld_r && pend_add_r) ? rdata : '0);

  always_comb begin
    state_nxt     = state_r;
    clr_nxt       = clr_r;
    nd_nxt        = nd_r;
    first_nxt     = first_r;
    req_nxt       = req_r;
    k_nxt         = k_r;
    acc_nxt       = cb_sum;
    pend_vld_nxt  = 1'b0;
    pend_add_nxt  = 1'b0;
    total_nxt     = total_r;
    res_nxt       = res_r;
    wr_en         = 1'b0;
    wr_addr       = nd_r;
    wr_data       = '0;
    rd_addr       = nd_r;
    go_right      = 1'b0;
    out_valid_nxt = out_valid_r && !out_ready;
    out_data_nxt  = out_data_r;

    case (state_r)
      S_CLEAR: begin
        wr_en   = 1'b1;
        wr_addr = clr_r;
        clr_nxt = clr_r + NODE_BITS'(1);
        if (clr_r == '1) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          req_nxt   = in_data.req_type;
          res_nxt   = '0;
          nd_nxt    = leaf;
          first_nxt = 1'b1;
          acc_nxt   = '0;
          case (in_data.req_type)
            REQ_INSERT: begin
              if (total_r == COUNT_MAX) begin
                res_nxt.status = ST_FULL;
                state_nxt      = S_DONE;
              end else begin
                rd_addr   = leaf;
                state_nxt = S_UPD;
              end
            end
            REQ_REMOVE: begin
              rd_addr   = leaf;
              state_nxt = S_UPD;
            end
            REQ_RANK, REQ_PRED, REQ_SUCC: begin
              state_nxt = S_CB;
            end
            REQ_KTH: begin
              if (in_data.position == '0 ||
                  CMP_BITS'(in_data.position) > CMP_BITS'(total_r)) begin
                res_nxt.status = ST_ABSENT;
                state_nxt      = S_DONE;
              end else begin
                k_nxt     = COUNT_BITS'(in_data.position);
                nd_nxt    = ROOT;
                rd_addr   = ROOT_LEFT;
                state_nxt = S_KTH;
              end
            end
            default: begin
              res_nxt.status = ST_ABSENT;
              state_nxt      = S_DONE;
            end
          endcase
        end
      end
      S_UPD: begin
        if (first_r && req_r == REQ_REMOVE && rdata == '0) begin
          res_nxt.status = ST_ABSENT;
          state_nxt      = S_DONE;
        end else begin
          wr_en     = 1'b1;
          wr_addr   = nd_r;
          wr_data   = (req_r == REQ_INSERT) ? rdata + COUNT_BITS'(1)
                                            : rdata - COUNT_BITS'(1);
          first_nxt = 1'b0;
          if (nd_r == ROOT) begin
            total_nxt = wr_data;
            state_nxt = S_DONE;
          end else begin
            nd_nxt  = nd_r >> 1;
            rd_addr = nd_r >> 1;
          end
        end
      end
      S_CB: begin
        pend_vld_nxt = 1'b1;
        if (first_r) begin
          rd_addr      = nd_r;
          pend_add_nxt = (req_r == REQ_SUCC);
          first_nxt    = 1'b0;
        end else begin
          rd_addr      = nd_r ^ NODE_BITS'(1);
          pend_add_nxt = nd_r[0];
          nd_nxt       = nd_r >> 1;
          if ((nd_r >> 1) == ROOT) begin
            state_nxt = S_CBT;
          end
        end
      end
      S_CBT: begin
        case (req_r)
          REQ_RANK: begin
            res_nxt.key_rank = RANK_BITS'(cb_sum) + RANK_BITS'(1);
            state_nxt        = S_DONE;
          end
          REQ_PRED: begin
            if (cb_sum == '0) begin
              res_nxt.status = ST_ABSENT;
              state_nxt      = S_DONE;
            end else begin
              k_nxt     = cb_sum;
              nd_nxt    = ROOT;
              rd_addr   = ROOT_LEFT;
              state_nxt = S_KTH;
            end
          end
          REQ_SUCC: begin
            if (cb_sum >= total_r) begin
              res_nxt.status = ST_ABSENT;
              state_nxt      = S_DONE;
            end else begin
              k_nxt     = cb_sum + COUNT_BITS'(1);
              nd_nxt    = ROOT;
              rd_addr   = ROOT_LEFT;
              state_nxt = S_KTH;
            end
          end
          default: begin
            state_nxt = S_DONE;
          end
        endcase
      end
      S_KTH: begin
        go_right = (k_r > rdata);
        k_nxt    = go_right ? k_r - rdata : k_r;
        nd_nxt   = {nd_r[NODE_BITS-2:0], go_right};
        rd_addr  = {nd_nxt[NODE_BITS-2:0], 1'b0};
        if (nd_nxt[NODE_BITS-1]) begin
          res_nxt.found_key = {~nd_nxt[KEY_BITS-1], nd_nxt[KEY_BITS-2:0]};
          state_nxt         = S_DONE;
        end
      end
      S_DONE: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = res_r;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_r       <= '0;
      total_r     <= '0;
      pend_vld_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      total_r     <= total_nxt;
      pend_vld_r  <= pend_vld_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    nd_r       <= nd_nxt;
    first_r    <= first_nxt;
    req_r      <= req_nxt;
    k_r        <= k_nxt;
    acc_r      <= acc_nxt;
    pend_add_r <= pend_add_nxt;
    res_r      <= res_nxt;
    out_data_r <= out_data_nxt;
  end

`ifndef SYNTHESIS
  a_fail_fields_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_data_r.status != ST_OK) |->
      (out_data_r.found_key == '0 && out_data_r.key_rank == '0))
    else $error("failed request carries a nonzero key or rank");

  a_total_step: assert property (@(posedge clk) disable iff (!rst_n)
    ($past(rst_n) && total_r != $past(total_r)) |->
      (total_r == $past(total_r) + COUNT_BITS'(1) ||
       total_r == $past(total_r) - COUNT_BITS'(1)))
    else $error("stored item count moved by more than one");

  a_kth_descent: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_KTH) |-> (!nd_r[NODE_BITS-1] && k_r != '0))
    else $error("order descent left the inner nodes or lost its index");
`endif

endmodule

// ----- rtl/core/osm_ram.sv -----
// Simple dual-port RAM with one write port and one registered read port.
module osm_ram #(
  parameter int ADDR_BITS = 13,
  parameter int DATA_BITS = 16
) (
  input  logic                 clk,
  input  logic                 wr_en,
  input  logic [ADDR_BITS-1:0] wr_addr,
  input  logic [DATA_BITS-1:0] wr_data,
  input  logic [ADDR_BITS-1:0] rd_addr,
  output logic [DATA_BITS-1:0] rd_data
);

  logic [DATA_BITS-1:0] mem [2**ADDR_BITS];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

endmodule

// ----- tb/osm_checker.sv -----
// Checker for the order-statistic multiset: watches both channels, predicts and compares results.
module osm_checker (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic              in_ready,
  input  osm_pkg::osm_in_t  in_data,
  input  logic              out_valid,
  input  logic              out_ready,
  input  osm_pkg::osm_out_t out_data,
  output int                fail_count,
  output int                outstanding
);
  import osm_pkg::*;

  localparam int                  SLOTS        = 1 << KEY_BITS;
  localparam logic [KEY_BITS-1:0] SIGN_FLIP    = KEY_BITS'(1) << (KEY_BITS - 1);

  int unsigned key_count [0:SLOTS-1];
  int unsigned stored_total;
  osm_out_t    expected_q[$];
  osm_out_t    oldest;

  initial begin
    for (int s = 0; s < SLOTS; s++) begin
      key_count[s] = 0;
    end
    stored_total = 0;
    fail_count   = 0;
    outstanding  = 0;
  end

  function automatic int unsigned count_before(int unsigned slot);
    int unsigned sum;
    sum = 0;
    for (int unsigned s = 0; s < slot; s++) begin
      sum += key_count[s];
    end
    return sum;
  endfunction

  function automatic logic [KEY_BITS-1:0] key_at_order(int unsigned k);
    int unsigned seen;
    int unsigned slot;
    seen = 0;
    slot = 0;
    while (seen + key_count[slot] < k) begin
      seen += key_count[slot];
      slot++;
    end
    return KEY_BITS'(slot) ^ SIGN_FLIP;
  endfunction

  function automatic osm_out_t apply_request(osm_in_t rq);
    osm_out_t            res;
    logic [KEY_BITS-1:0] slot_bits;
    int unsigned         slot;
    int unsigned         below;
    res       = '0;
    res.status = ST_OK;
    slot_bits = rq.key ^ SIGN_FLIP;
    slot      = 32'(slot_bits);
    case (rq.req_type)
      REQ_INSERT: begin
        if (stored_total >= COUNT_MAX) begin
          res.status = ST_FULL;
        end else begin
          key_count[slot]++;
          stored_total++;
        end
      end
      REQ_REMOVE: begin
        if (key_count[slot] == 0) begin
          res.status = ST_ABSENT;
        end else begin
          key_count[slot]--;
          stored_total--;
        end
      end
      REQ_RANK: begin
        res.key_rank = RANK_BITS'(count_before(slot) + 1);
      end
      REQ_KTH: begin
        if (rq.position == 0 || rq.position > stored_total) begin
          res.status = ST_ABSENT;
        end else begin
          res.found_key = key_at_order(32'(rq.position));
        end
      end
      REQ_PRED: begin
        below = count_before(slot);
        if (below == 0) begin
          res.status = ST_ABSENT;
        end else begin
          res.found_key = key_at_order(below);
        end
      end
      REQ_SUCC: begin
        below = count_before(slot) + key_count[slot];
        if (below >= stored_total) begin
          res.status = ST_ABSENT;
        end else begin
          res.found_key = key_at_order(below + 1);
        end
      end
      default: begin
        res.status = ST_ABSENT;
      end
    endcase
    return res;
  endfunction

  task automatic compare_field(input string name, input int expv, input int gotv);
    if (expv != gotv) begin
      $error("%s: expected %0d, got %0d", name, expv, gotv);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && out_ready) begin
        if (expected_q.size() == 0) begin
          $error("result item arrived with no request outstanding");
          fail_count++;
        end else begin
          oldest = expected_q.pop_front();
          compare_field("found_key", int'(oldest.found_key), int'(out_data.found_key));
          compare_field("key_rank", int'(oldest.key_rank), int'(out_data.key_rank));
          compare_field("status", int'(oldest.status), int'(out_data.status));
        end
      end
      if (in_valid && in_ready) begin
        expected_q.push_back(apply_request(in_data));
      end
      outstanding <= expected_q.size();
    end
  end

endmodule

// ----- tb/tb.sv -----
// Top-level testbench for the order-statistic multiset: clock, reset, stimulus and verdict.
module tb;
  import osm_pkg::*;

  localparam logic [REQ_BITS-1:0] REQ_UNUSED_LO = 3'd6;
  localparam logic [REQ_BITS-1:0] REQ_UNUSED_HI = 3'd7;
  localparam int RANDOM_ITEMS = 1617;
  localparam int DRAIN_LIMIT  = 20000;
  localparam int KEY_MIN      = -(1 << (KEY_BITS - 1));
  localparam int KEY_MAX      = (1 << (KEY_BITS - 1)) - 1;

  logic     clk = 1'b0;
  logic     rst_n = 1'b0;
  logic     in_valid = 1'b0;
  logic     in_ready;
  osm_in_t  in_data = '0;
  logic     out_valid;
  logic     out_ready = 1'b0;
  osm_out_t out_data;
  logic     idle_on = 1'b1;
  int       stall_left = 0;
  int       fail_count;
  int       outstanding;

  order_statistic_multiset uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  osm_checker checker_i (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_data     (in_data),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_data    (out_data),
    .fail_count  (fail_count),
    .outstanding (outstanding)
  );

  always #1 clk = ~clk;

  always @(posedge clk) begin
    if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      out_ready  <= 1'b0;
    end else if (idle_on && $urandom_range(0, 9) == 0) begin
      stall_left <= $urandom_range(1, 14) - 1;
      out_ready  <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  task automatic send_request(input logic [REQ_BITS-1:0] op, input int k, input int p);
    osm_in_t item;
    item.req_type = op;
    item.key      = KEY_BITS'(k);
    item.position = POS_BITS'(p);
    if (idle_on && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= item;
    do @(posedge clk); while (!in_ready);
  endtask

  initial begin
    #2000000;
    $display("Test completed with failures");
    $finish;
  end

  initial begin
    int                  hot_keys [16];
    int                  roll;
    int                  k;
    int                  p;
    int                  waited;
    logic [REQ_BITS-1:0] op;

    for (int h = 0; h < 16; h++) begin
      hot_keys[h] = int'($urandom_range(0, 4095)) - 2048;
    end
    hot_keys[0] = KEY_MIN;
    hot_keys[1] = KEY_MAX;
    hot_keys[2] = 0;
    hot_keys[3] = -1;

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    send_request(REQ_PRED, 0, 0);
    send_request(REQ_SUCC, 0, 0);
    send_request(REQ_KTH, 0, 1);
    send_request(REQ_REMOVE, 5, 0);
    send_request(REQ_RANK, KEY_MIN, 0);
    send_request(REQ_INSERT, KEY_MIN, 0);
    send_request(REQ_INSERT, KEY_MAX, 0);
    send_request(REQ_INSERT, 0, 0);
    send_request(REQ_INSERT, 0, 16'hffff);
    send_request(REQ_RANK, KEY_MAX, 0);
    send_request(REQ_RANK, 0, 0);
    send_request(REQ_KTH, 0, 1);
    send_request(REQ_KTH, 0, 4);
    send_request(REQ_KTH, 0, 0);
    send_request(REQ_KTH, 0, 5);
    send_request(REQ_KTH, -1, 16'hffff);
    send_request(REQ_PRED, KEY_MIN, 0);
    send_request(REQ_SUCC, KEY_MAX, 0);
    send_request(REQ_PRED, KEY_MAX, 0);
    send_request(REQ_SUCC, KEY_MIN, 0);
    send_request(REQ_SUCC, 0, 0);
    send_request(REQ_UNUSED_LO, 0, 0);
    send_request(REQ_UNUSED_HI, -1, 16'hffff);
    send_request(REQ_REMOVE, 0, 0);
    send_request(REQ_REMOVE, KEY_MAX, 0);

    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      idle_on <= (i < RANDOM_ITEMS - 300) && (i % 400 < 300);
      roll = $urandom_range(0, 99);
      if (roll < 30) op = REQ_INSERT;
      else if (roll < 50) op = REQ_REMOVE;
      else if (roll < 62) op = REQ_RANK;
      else if (roll < 75) op = REQ_KTH;
      else if (roll < 85) op = REQ_PRED;
      else if (roll < 95) op = REQ_SUCC;
      else if (roll < 98) op = REQ_UNUSED_LO;
      else op = REQ_UNUSED_HI;
      if ($urandom_range(0, 9) < 6) k = hot_keys[$urandom_range(0, 15)];
      else k = int'($urandom_range(0, 4095)) - 2048;
      roll = $urandom_range(0, 9);
      if (roll < 7) p = $urandom_range(0, 400);
      else if (roll < 9) p = $urandom_range(0, 4);
      else p = $urandom_range(0, 65535);
      send_request(op, k, p);
    end

    idle_on <= 1'b0;
    send_request(REQ_INSERT, KEY_MAX, 0);
    send_request(REQ_KTH, 0, 16'hffff);
    send_request(REQ_PRED, KEY_MAX, 0);
    send_request(REQ_SUCC, KEY_MIN, 0);
    for (int i = 0; i < 100; i++) begin
      send_request(REQ_REMOVE, KEY_MAX, 0);
    end
    for (int i = 0; i < 100; i++) begin
      send_request(REQ_INSERT, 0, 0);
    end
    send_request(REQ_RANK, KEY_MAX, 0);
    send_request(REQ_KTH, 0, 16'hffff);
    send_request(REQ_KTH, 0, 0);
    send_request(REQ_SUCC, KEY_MAX - 1, 0);
    in_valid <= 1'b0;

    waited = 0;
    while (outstanding != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    repeat (60) @(posedge clk);
    if (fail_count == 0 && outstanding == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

// ----- files.f -----
rtl/core/osm_pkg.sv
rtl/core/osm_ram.sv
rtl/core/order_statistic_multiset.sv
tb/osm_checker.sv
tb/tb.sv
